>>> src/rbdep_pkg.sv
// Package for the double-ended ring buffer: field widths, action codes,
// sequencer states and the structs that join controller, datapath and config.
// No dependencies.
package rbdep_pkg;

	// Fixed field widths
	localparam int ACT_W  = 3;
	localparam int CNT_W  = 11;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register word index of capacity
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH      = 3'd0,
		ACT_POP_FRONT = 3'd1,
		ACT_POP_REAR  = 3'd2,
		ACT_CLEAR     = 3'd3,
		ACT_QUERY     = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_UPDATE = 2'd1,
		ST_FETCH  = 2'd2,
		ST_LOAD   = 2'd3
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic fetch;
		logic load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} status_t;

	// Config register to datapath
	typedef struct packed {
		logic             wr;
		logic [CNT_W-1:0] cap;
	} cfg_t;

endpackage

>>> src/rbdep_in_if.sv
// Input channel of the ring buffer: valid/ready with action and entry word.
// Depends on rbdep_pkg.
interface rbdep_in_if #(
	parameter int ENTRY_WIDTH = 64
) ();
	import rbdep_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [ACT_W-1:0]       action;
	logic [ENTRY_WIDTH-1:0] entry_in;

	modport source (output valid, action, entry_in, input ready);
	modport sink   (input valid, action, entry_in, output ready);
endinterface

>>> src/rbdep_out_if.sv
// Result channel of the ring buffer: valid/ready with status and end entries.
// Depends on rbdep_pkg.
interface rbdep_out_if #(
	parameter int ENTRY_WIDTH = 64
) ();
	import rbdep_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   ok;
	logic [CNT_W-1:0]       count;
	logic                   is_empty;
	logic                   is_full;
	logic [ENTRY_WIDTH-1:0] front_entry;
	logic [ENTRY_WIDTH-1:0] back_entry;

	modport source (output valid, ok, count, is_empty, is_full, front_entry, back_entry,
		input ready);
	modport sink   (input valid, ok, count, is_empty, is_full, front_entry, back_entry,
		output ready);
endinterface

>>> src/ring_buffer_double_ended_pop.sv
// Top level of the double-ended ring buffer: sequencer, datapath, register.
// Depends on rbdep_pkg, rbdep_in_if, rbdep_out_if, rbdep_cfg, rbdep_ctrl,
// rbdep_datapath.
//
//  Port    | Kind        | Beat carries
//  --------+-------------+------------------------------------------------
//  item    | valid/ready | action, entry_in
//  result  | valid/ready | ok, count, is_empty, is_full, front/back entry
//  APB     | psel/penable| capacity register at byte address 0
//
// An action passes in order through accept, index update and slot write,
// two-port slot read and result load; a new beat is accepted only after the
// previous action's load. The next beat is accepted while a result still
// waits; its load stalls until the waiting result is taken.
// Reset clears indices and count and sets capacity to min(1024, DEPTH); slot
// contents are not cleared. A capacity write empties the ring.
module ring_buffer_double_ended_pop #(
	parameter int DEPTH       = 1024,
	parameter int ENTRY_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rbdep_in_if.sink                     item,
	rbdep_out_if.source                  result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rbdep_pkg::APB_AW-1:0] paddr,
	input  logic [rbdep_pkg::APB_DW-1:0] pwdata,
	output logic [rbdep_pkg::APB_DW-1:0] prdata,
	output logic                         pready
);
	import rbdep_pkg::*;

	cmd_t    cmd;
	status_t status;
	cfg_t    cfg;

	rbdep_cfg #(
		.DEPTH (DEPTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbdep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	rbdep_datapath #(
		.DEPTH       (DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.status      (status),
		.action      (item.action),
		.entry_in    (item.entry_in),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.ok          (result.ok),
		.count       (result.count),
		.is_empty    (result.is_empty),
		.is_full     (result.is_full),
		.front_entry (result.front_entry),
		.back_entry  (result.back_entry)
	);

endmodule

>>> src/rbdep_cfg.sv
// APB-style register file for the ring buffer: holds the clamped capacity.
// Depends on rbdep_pkg.
module rbdep_cfg #(
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rbdep_pkg::APB_AW-1:0] paddr,
	input  logic [rbdep_pkg::APB_DW-1:0] pwdata,
	output logic [rbdep_pkg::APB_DW-1:0] prdata,
	output logic                      pready,
	output rbdep_pkg::cfg_t           cfg
);
	import rbdep_pkg::*;

	localparam logic [CNT_W-1:0] CAP_RST = (DEPTH < 1024) ? CNT_W'(DEPTH) : CNT_W'(1024);

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] raw;
	logic [CNT_W-1:0] cap_d;
	logic             wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

	// Clamp written value into 1..DEPTH
	always_comb begin
		raw = pwdata[CNT_W-1:0];
		priority if (raw == '0) begin
			cap_d = CNT_W'(1);
		end else if (32'(raw) > DEPTH) begin
			cap_d = CNT_W'(DEPTH);
		end else begin
			cap_d = raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
		end else if (wr) begin
			cap_q <= cap_d;
		end
	end

	// Read back the capacity word; other words read zero
	assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

	assign cfg.wr  = wr;
	assign cfg.cap = cap_q;

endmodule

>>> src/rbdep_ctrl.sv
// Sequencer for the ring buffer: walks each action through update, memory
// read and result load. Depends on rbdep_pkg.
module rbdep_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rbdep_pkg::status_t status,
	output rbdep_pkg::cmd_t    cmd
);
	import rbdep_pkg::*;

	state_t state_q;
	state_t state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_LOAD;
			ST_LOAD:   if (status.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_UPDATE: cmd.update = 1'b1;
			ST_FETCH:  cmd.fetch  = 1'b1;
			ST_LOAD:   cmd.load   = status.out_free;
			default:   cmd        = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one datapath command at once");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> status.out_free) else $error("result loaded over an untaken one");
	a_capture_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.update) else $error("captured beat not updated next cycle");
`endif

endmodule

>>> src/rbdep_datapath.sv
// Ring buffer datapath: slot memory, head/tail/occupancy and result register.
// Depends on rbdep_pkg.
module rbdep_datapath #(
	parameter int DEPTH       = 1024,
	parameter int ENTRY_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rbdep_pkg::cmd_t               cmd,
	input  rbdep_pkg::cfg_t               cfg,
	output rbdep_pkg::status_t            status,
	input  logic [rbdep_pkg::ACT_W-1:0]   action,
	input  logic [ENTRY_WIDTH-1:0]        entry_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [rbdep_pkg::CNT_W-1:0]   count,
	output logic                          is_empty,
	output logic                          is_full,
	output logic [ENTRY_WIDTH-1:0]        front_entry,
	output logic [ENTRY_WIDTH-1:0]        back_entry
);
	import rbdep_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i,
		input logic [CNT_W-1:0] c);
		logic [31:0] n;
		n = 32'(i) + 32'd1;
		return (n >= 32'(c)) ? '0 : IDX_W'(n);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_prev(input logic [IDX_W-1:0] i,
		input logic [CNT_W-1:0] c);
		return (i == '0) ? IDX_W'(c - CNT_W'(1)) : IDX_W'(i - IDX_W'(1));
	endfunction

	logic [ENTRY_WIDTH-1:0] mem [DEPTH];

	logic [ACT_W-1:0]       action_q;
	logic [ENTRY_WIDTH-1:0] entry_q;
	logic [IDX_W-1:0]       head_q, tail_q;
	logic [CNT_W-1:0]       occ_q;
	logic                   ok_q;
	logic [IDX_W-1:0]       head_d, tail_d;
	logic [CNT_W-1:0]       occ_d;
	logic                   ok_d;
	logic                   we;
	logic [ENTRY_WIDTH-1:0] rd_front_q, rd_back_q;
	logic                   out_valid_q;
	logic                   out_ok_q, out_empty_q, out_full_q;
	logic [CNT_W-1:0]       out_count_q;
	logic [ENTRY_WIDTH-1:0] out_front_q, out_back_q;

	// Hold the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			entry_q  <= entry_in;
		end
	end

	// Work out the action's effect on the indices
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		occ_d  = occ_q;
		ok_d   = 1'b0;
		we     = 1'b0;
		unique case (action_q)
			ACT_PUSH: if (occ_q < cfg.cap) begin
				we     = 1'b1;
				tail_d = wrap_next(tail_q, cfg.cap);
				occ_d  = CNT_W'(occ_q + CNT_W'(1));
				ok_d   = 1'b1;
			end
			ACT_POP_FRONT: if (occ_q != '0) begin
				head_d = wrap_next(head_q, cfg.cap);
				occ_d  = CNT_W'(occ_q - CNT_W'(1));
				ok_d   = 1'b1;
			end
			ACT_POP_REAR: if (occ_q != '0) begin
				tail_d = wrap_prev(tail_q, cfg.cap);
				occ_d  = CNT_W'(occ_q - CNT_W'(1));
				ok_d   = 1'b1;
			end
			ACT_CLEAR: begin
				head_d = '0;
				tail_d = '0;
				occ_d  = '0;
				ok_d   = 1'b1;
			end
			ACT_QUERY: ok_d = 1'b1;
			default:   ok_d = 1'b0;
		endcase
	end

	// Advance indices; a capacity write empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else if (cfg.wr) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else if (cmd.update) begin
			head_q <= head_d;
			tail_q <= tail_d;
			occ_q  <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) ok_q <= ok_d;
	end

	// Slot memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.update && we) mem[tail_q] <= entry_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rd_front_q <= mem[head_q];
			rd_back_q  <= mem[wrap_prev(tail_q, cfg.cap)];
		end
	end

	// Result register
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_ok_q    <= ok_q;
			out_count_q <= occ_q;
			out_empty_q <= (occ_q == '0);
			out_full_q  <= (occ_q == cfg.cap);
			out_front_q <= (occ_q == '0) ? '0 : rd_front_q;
			out_back_q  <= (occ_q == '0) ? '0 : rd_back_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_ok_q;
	assign count       = out_count_q;
	assign is_empty    = out_empty_q;
	assign is_full     = out_full_q;
	assign front_entry = out_front_q;
	assign back_entry  = out_back_q;

`ifndef SYNTHESIS
	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cfg.cap) else $error("occupancy above capacity");
	a_head_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < 32'(cfg.cap)) else $error("head index past wrap point");
	a_tail_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tail_q) < 32'(cfg.cap)) else $error("tail index past wrap point");
`endif

endmodule
